/* sv/csl_pkg.sv */
// Shared types, codes and helper functions of the C-subset lexer.
package csl_pkg;

    localparam int OUT_OFF_W = 20;
    localparam int OUT_LIT_W = 16;
    localparam int RES_MAX   = 3;
    localparam logic [62:0] VAL_MAX = {63{1'b1}};

    // Token kinds
    localparam logic [4:0] KIND_PUNCT  = 5'd0;
    localparam logic [4:0] KIND_STRING = 5'd1;
    localparam logic [4:0] KIND_CHAR   = 5'd2;
    localparam logic [4:0] KIND_NUMBER = 5'd3;
    localparam logic [4:0] KIND_IDENT  = 5'd4;
    localparam logic [4:0] KIND_KW0    = 5'd5;
    localparam logic [4:0] KIND_END    = 5'd18;

    // Punctuator codes
    localparam logic [4:0] P_STAR    = 5'd0;
    localparam logic [4:0] P_SLASH   = 5'd1;
    localparam logic [4:0] P_LPAREN  = 5'd2;
    localparam logic [4:0] P_RPAREN  = 5'd3;
    localparam logic [4:0] P_LBRACE  = 5'd4;
    localparam logic [4:0] P_RBRACE  = 5'd5;
    localparam logic [4:0] P_SEMI    = 5'd6;
    localparam logic [4:0] P_COMMA   = 5'd7;
    localparam logic [4:0] P_LBRACK  = 5'd8;
    localparam logic [4:0] P_RBRACK  = 5'd9;
    localparam logic [4:0] P_HASH    = 5'd10;
    localparam logic [4:0] P_ANDAND  = 5'd11;
    localparam logic [4:0] P_AND     = 5'd12;
    localparam logic [4:0] P_OROR    = 5'd13;
    localparam logic [4:0] P_INC     = 5'd14;
    localparam logic [4:0] P_PLUS    = 5'd15;
    localparam logic [4:0] P_ELLIPS  = 5'd16;
    localparam logic [4:0] P_DOT     = 5'd17;
    localparam logic [4:0] P_DEC     = 5'd18;
    localparam logic [4:0] P_ARROW   = 5'd19;
    localparam logic [4:0] P_MINUS   = 5'd20;
    localparam logic [4:0] P_LE      = 5'd21;
    localparam logic [4:0] P_LT      = 5'd22;
    localparam logic [4:0] P_GE      = 5'd23;
    localparam logic [4:0] P_GT      = 5'd24;
    localparam logic [4:0] P_EQEQ    = 5'd25;
    localparam logic [4:0] P_ASSIGN  = 5'd26;
    localparam logic [4:0] P_NE      = 5'd27;
    localparam logic [4:0] P_NOT     = 5'd28;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_COMMENT   = 3'd1;
    localparam logic [2:0] ERR_STRING    = 3'd2;
    localparam logic [2:0] ERR_CHARQUOTE = 3'd3;
    localparam logic [2:0] ERR_BADBYTE   = 3'd4;

    typedef enum logic [4:0] {
        M_IDLE, M_SLASH, M_OP1, M_DOT, M_DOT2, M_IDENT, M_NUM, M_LINEC,
        M_BLOCKC, M_BLOCKSTAR, M_STR, M_STRESC, M_CHOPEN, M_CHPLAIN,
        M_CHBS, M_CHQ, M_CHDIG
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]           kind;
        logic [4:0]           punct;
        logic [OUT_OFF_W-1:0] start;
        logic [OUT_OFF_W-1:0] len;
        logic [62:0]          value;
        logic [OUT_LIT_W-1:0] lit;
        logic [2:0]           err;
    } result_t;

    typedef result_t [RES_MAX-1:0] res_set_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word_head(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    // Append one decimal digit, saturating at the value maximum
    function automatic logic [62:0] dec_push(input logic [62:0] acc, input logic [3:0] d);
        logic [66:0] t;
        t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 67'(d);
        return (t > 67'(VAL_MAX)) ? VAL_MAX : t[62:0];
    endfunction

    // Escape table: {hit, value}
    function automatic logic [8:0] esc_lookup(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h65:   r = {1'b1, 8'h1b};
            8'h66:   r = {1'b1, 8'h0c};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h72:   r = {1'b1, 8'h0d};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0b};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3f:   r = {1'b1, 8'h3f};
            default: r = {1'b0, c};
        endcase
        return r;
    endfunction

    // Two-byte operator: {hit, code}
    function automatic logic [5:0] pair_code(input logic [7:0] f, input logic [7:0] c);
        logic [5:0] r;
        r = 6'b0;
        priority if (f == 8'h26 && c == 8'h26) r = {1'b1, P_ANDAND};
        else if (f == 8'h7c && c == 8'h7c) r = {1'b1, P_OROR};
        else if (f == 8'h2b && c == 8'h2b) r = {1'b1, P_INC};
        else if (f == 8'h2d && c == 8'h2d) r = {1'b1, P_DEC};
        else if (f == 8'h2d && c == 8'h3e) r = {1'b1, P_ARROW};
        else if (f == 8'h3c && c == 8'h3d) r = {1'b1, P_LE};
        else if (f == 8'h3e && c == 8'h3d) r = {1'b1, P_GE};
        else if (f == 8'h3d && c == 8'h3d) r = {1'b1, P_EQEQ};
        else if (f == 8'h21 && c == 8'h3d) r = {1'b1, P_NE};
        else r = 6'b0;
        return r;
    endfunction

    // One-byte operator: {hit, code}; a lone bar has none
    function automatic logic [5:0] single_code(input logic [7:0] f);
        logic [5:0] r;
        unique case (f)
            8'h26:   r = {1'b1, P_AND};
            8'h2b:   r = {1'b1, P_PLUS};
            8'h2d:   r = {1'b1, P_MINUS};
            8'h3c:   r = {1'b1, P_LT};
            8'h3e:   r = {1'b1, P_GT};
            8'h3d:   r = {1'b1, P_ASSIGN};
            8'h21:   r = {1'b1, P_NOT};
            default: r = 6'b0;
        endcase
        return r;
    endfunction

    // Keyword match on length and last six bytes
    function automatic logic [4:0] word_kind(input logic [2:0] len, input logic len_small,
                                             input logic [47:0] wp);
        logic [4:0] k;
        k = KIND_IDENT;
        if (len_small) begin
            priority if (len == 3'd6 && wp == 48'h72_65_74_75_72_6e) k = KIND_KW0;
            else if (len == 3'd2 && wp == 48'h69_66) k = KIND_KW0 + 5'd1;
            else if (len == 3'd4 && wp == 48'h65_6c_73_65) k = KIND_KW0 + 5'd2;
            else if (len == 3'd5 && wp == 48'h77_68_69_6c_65) k = KIND_KW0 + 5'd3;
            else if (len == 3'd3 && wp == 48'h66_6f_72) k = KIND_KW0 + 5'd4;
            else if (len == 3'd4 && wp == 48'h65_6e_75_6d) k = KIND_KW0 + 5'd5;
            else if (len == 3'd3 && wp == 48'h69_6e_74) k = KIND_KW0 + 5'd6;
            else if (len == 3'd4 && wp == 48'h6c_6f_6e_67) k = KIND_KW0 + 5'd7;
            else if (len == 3'd4 && wp == 48'h76_6f_69_64) k = KIND_KW0 + 5'd8;
            else if (len == 3'd6 && wp == 48'h73_74_72_75_63_74) k = KIND_KW0 + 5'd9;
            else if (len == 3'd5 && wp == 48'h75_6e_69_6f_6e) k = KIND_KW0 + 5'd10;
            else if (len == 3'd6 && wp == 48'h73_69_7a_65_6f_66) k = KIND_KW0 + 5'd11;
            else if (len == 3'd4 && wp == 48'h63_68_61_72) k = KIND_KW0 + 5'd12;
            else k = KIND_IDENT;
        end
        return k;
    endfunction

endpackage

/* sv/c_subset_lexer.sv */
// Streaming C-subset lexer: one source byte in, zero to three token words out.
// The first token word of a byte is presented on m_ the cycle after the byte that completes it.
// Throughput: one byte per cycle while each byte yields at most one word and m_tready is high;
// a byte yielding several words holds off the next byte while the single result port drains the buffer.
// Reset (aresetn low, synchronous): lexer idle, offsets, literal ids and buffer cleared.
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS     = 20,
    parameter int LITERAL_ID_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // ch[7:0]
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // punct_code, start_offset, token_length, token_value,
                                    // literal_id, error_code, zero pad
    output logic [4:0]   m_tuser,   // token_kind
    output logic         m_tlast    // last
);

    res_set_t   step_res;
    logic [1:0] step_count;
    logic       s_accept;
    logic       m_accept;
    logic [1:0] remain;

    result_t    res_reg [RES_MAX];
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    result_t    cur;

    csl_step #(
        .OFFSET_BITS    (OFFSET_BITS),
        .LITERAL_ID_BITS(LITERAL_ID_BITS)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .ch       (s_tdata),
        .eoi      (s_tlast),
        .res      (step_res),
        .res_count(step_count)
    );

    // Take a new byte once the buffer empties this cycle
    assign remain   = cnt_reg - rd_reg;
    assign m_tvalid = remain != 2'd0;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (remain == 2'd0) || (remain == 2'd1 && m_tready);
    assign s_accept = s_tvalid && s_tready;

    // Buffer pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else if (s_accept) begin
            cnt_reg <= step_count;
            rd_reg  <= 2'd0;
        end else if (m_accept) begin
            rd_reg <= rd_reg + 2'd1;
        end
    end

    // Load the words of the accepted byte
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < RES_MAX; i++) begin
                res_reg[i] <= step_res[i];
            end
        end
    end

    // Present the current word
    assign cur     = res_reg[rd_reg];
    assign m_tuser = cur.kind;
    assign m_tlast = (rd_reg + 2'd1) == cnt_reg;
    assign m_tdata = {1'b0, cur.err, cur.lit, cur.value, cur.len, cur.start, cur.punct};

endmodule

/* sv/csl_step.sv */
// Lexer state registers and the per-byte next-state and token logic.
module csl_step
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS     = 20,
    parameter int LITERAL_ID_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     ch,
    input  logic           eoi,
    output res_set_t       res,
    output logic [1:0]     res_count
);

    localparam logic [OFFSET_BITS-1:0]     OMAX = '1;
    localparam logic [LITERAL_ID_BITS-1:0] LMAX = '1;

    scan_mode_t                 mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]     tstart_reg, tstart_next;
    logic [OFFSET_BITS-1:0]     tlen_reg, tlen_next;
    logic [OFFSET_BITS-1:0]     pos_reg, pos_next;
    logic [62:0]                acc_reg, acc_next;
    logic [47:0]                wp_reg, wp_next;
    logic [LITERAL_ID_BITS-1:0] nlit_reg, nlit_next;
    logic [7:0]                 esc_reg, esc_next;
    logic                       errl_reg, errl_next;

    function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] x);
        return (x == OMAX) ? x : x + 1'b1;
    endfunction

    function automatic result_t mk(input logic [4:0] kind, input logic [4:0] pc,
                                   input logic [OFFSET_BITS-1:0] st,
                                   input logic [OFFSET_BITS-1:0] ln,
                                   input logic [62:0] val,
                                   input logic [LITERAL_ID_BITS-1:0] lit,
                                   input logic [2:0] err);
        result_t r;
        logic [31:0] s32, l32, i32;
        s32 = 32'(st);
        l32 = 32'(ln);
        i32 = 32'(lit);
        r.kind  = kind;
        r.punct = pc;
        r.start = s32[OUT_OFF_W-1:0];
        r.len   = l32[OUT_OFF_W-1:0];
        r.value = val;
        r.lit   = i32[OUT_LIT_W-1:0];
        r.err   = err;
        return r;
    endfunction

    localparam logic [OFFSET_BITS-1:0] L0 = '0;
    localparam logic [OFFSET_BITS-1:0] L1 = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] L2 = OFFSET_BITS'(2);
    localparam logic [OFFSET_BITS-1:0] L3 = OFFSET_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] L4 = OFFSET_BITS'(4);
    localparam logic [LITERAL_ID_BITS-1:0] NOLIT = '0;

    // Compute next state and the tokens this word completes
    always_comb begin
        logic [1:0]             n;
        logic                   redo;
        logic [5:0]             pcode;
        logic [8:0]             eres;
        logic [OFFSET_BITS-1:0] tinc;
        logic [4:0]             wk;
        n           = 2'd0;
        redo        = 1'b0;
        pcode       = 6'b0;
        eres        = 9'b0;
        res         = '0;
        tinc        = inc_off(tlen_reg);
        wk          = word_kind(tlen_reg[2:0], tlen_reg < L4 + L3, wp_reg);
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        wp_next     = wp_reg;
        nlit_next   = nlit_reg;
        esc_next    = esc_reg;
        errl_next   = errl_reg;
        if (accept && eoi) begin
            // flush pending token, then end token and restart
            if (!errl_reg) begin
                unique case (mode_reg)
                    M_SLASH: begin
                        res[n] = mk(KIND_PUNCT, P_SLASH, tstart_reg, L1, '0, NOLIT, ERR_NONE);
                        n = n + 2'd1;
                    end
                    M_OP1: begin
                        pcode = single_code(esc_reg);
                        if (pcode[5]) res[n] = mk(KIND_PUNCT, pcode[4:0], tstart_reg, L1,
                                                  '0, NOLIT, ERR_NONE);
                        else res[n] = mk(KIND_END, P_STAR, tstart_reg, L0, '0, NOLIT,
                                         ERR_BADBYTE);
                        n = n + 2'd1;
                    end
                    M_DOT: begin
                        res[n] = mk(KIND_PUNCT, P_DOT, tstart_reg, L1, '0, NOLIT, ERR_NONE);
                        n = n + 2'd1;
                    end
                    M_DOT2: begin
                        res[n] = mk(KIND_PUNCT, P_DOT, tstart_reg, L1, '0, NOLIT, ERR_NONE);
                        n = n + 2'd1;
                        res[n] = mk(KIND_PUNCT, P_DOT, inc_off(tstart_reg), L1, '0, NOLIT,
                                    ERR_NONE);
                        n = n + 2'd1;
                    end
                    M_IDENT: begin
                        res[n] = mk(wk, P_STAR, tstart_reg, tlen_reg, '0, NOLIT, ERR_NONE);
                        n = n + 2'd1;
                    end
                    M_NUM: begin
                        res[n] = mk(KIND_NUMBER, P_STAR, tstart_reg, tlen_reg, acc_reg,
                                    NOLIT, ERR_NONE);
                        n = n + 2'd1;
                    end
                    M_BLOCKC, M_BLOCKSTAR: begin
                        res[n] = mk(KIND_END, P_STAR, tstart_reg, L0, '0, NOLIT, ERR_COMMENT);
                        n = n + 2'd1;
                    end
                    M_STR, M_STRESC: begin
                        res[n] = mk(KIND_END, P_STAR, pos_reg, L0, '0, NOLIT, ERR_STRING);
                        n = n + 2'd1;
                    end
                    M_CHOPEN, M_CHPLAIN, M_CHBS, M_CHQ, M_CHDIG: begin
                        res[n] = mk(KIND_END, P_STAR, pos_reg, L0, '0, NOLIT, ERR_CHARQUOTE);
                        n = n + 2'd1;
                    end
                    default: ;
                endcase
            end
            res[n] = mk(KIND_END, P_STAR, pos_reg, L1, '0, NOLIT, ERR_NONE);
            n = n + 2'd1;
            mode_next   = M_IDLE;
            tstart_next = '0;
            tlen_next   = '0;
            pos_next    = '0;
            acc_next    = '0;
            wp_next     = '0;
            esc_next    = '0;
            errl_next   = 1'b0;
        end else if (accept) begin
            if (!errl_reg) begin
                // continue the open token
                unique case (mode_reg)
                    M_IDLE: redo = 1'b1;
                    M_SLASH: begin
                        if (ch == 8'h2f) mode_next = M_LINEC;
                        else if (ch == 8'h2a) mode_next = M_BLOCKC;
                        else begin
                            res[n] = mk(KIND_PUNCT, P_SLASH, tstart_reg, L1, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_OP1: begin
                        pcode = pair_code(esc_reg, ch);
                        if (pcode[5]) begin
                            res[n] = mk(KIND_PUNCT, pcode[4:0], tstart_reg, L2, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end else begin
                            pcode = single_code(esc_reg);
                            if (pcode[5]) begin
                                res[n] = mk(KIND_PUNCT, pcode[4:0], tstart_reg, L1, '0,
                                            NOLIT, ERR_NONE);
                                n = n + 2'd1;
                                redo = 1'b1;
                            end else begin
                                res[n] = mk(KIND_END, P_STAR, tstart_reg, L0, '0, NOLIT,
                                            ERR_BADBYTE);
                                n = n + 2'd1;
                                errl_next = 1'b1;
                                mode_next = M_IDLE;
                            end
                        end
                    end
                    M_DOT: begin
                        if (ch == 8'h2e) mode_next = M_DOT2;
                        else begin
                            res[n] = mk(KIND_PUNCT, P_DOT, tstart_reg, L1, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_DOT2: begin
                        if (ch == 8'h2e) begin
                            res[n] = mk(KIND_PUNCT, P_ELLIPS, tstart_reg, L3, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end else begin
                            res[n] = mk(KIND_PUNCT, P_DOT, tstart_reg, L1, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            res[n] = mk(KIND_PUNCT, P_DOT, inc_off(tstart_reg), L1, '0,
                                        NOLIT, ERR_NONE);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (is_word_head(ch) || is_digit(ch)) begin
                            wp_next   = {wp_reg[39:0], ch};
                            tlen_next = tinc;
                        end else begin
                            res[n] = mk(wk, P_STAR, tstart_reg, tlen_reg, '0, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_NUM: begin
                        if (is_digit(ch)) begin
                            acc_next  = dec_push(acc_reg, ch[3:0]);
                            tlen_next = tinc;
                        end else begin
                            res[n] = mk(KIND_NUMBER, P_STAR, tstart_reg, tlen_reg, acc_reg,
                                        NOLIT, ERR_NONE);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    M_LINEC: if (ch == 8'h0a) mode_next = M_IDLE;
                    M_BLOCKC: if (ch == 8'h2a) mode_next = M_BLOCKSTAR;
                    M_BLOCKSTAR: begin
                        if (ch == 8'h2f) mode_next = M_IDLE;
                        else if (ch != 8'h2a) mode_next = M_BLOCKC;
                    end
                    M_STR: begin
                        tlen_next = tinc;
                        if (ch == 8'h5c) mode_next = M_STRESC;
                        else if (ch == 8'h22) begin
                            res[n] = mk(KIND_STRING, P_STAR, tstart_reg, tinc, '0, nlit_reg,
                                        ERR_NONE);
                            n = n + 2'd1;
                            nlit_next = (nlit_reg == LMAX) ? nlit_reg : nlit_reg + 1'b1;
                            mode_next = M_IDLE;
                        end
                    end
                    M_STRESC: begin
                        tlen_next = tinc;
                        mode_next = M_STR;
                    end
                    M_CHOPEN: begin
                        if (ch == 8'h5c) mode_next = M_CHBS;
                        else begin
                            acc_next  = 63'(ch);
                            mode_next = M_CHPLAIN;
                        end
                    end
                    M_CHPLAIN: begin
                        res[n] = mk(KIND_CHAR, P_STAR, tstart_reg, L3, acc_reg, NOLIT,
                                    ERR_NONE);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    M_CHBS: begin
                        eres = esc_lookup(ch);
                        if (!eres[8] && is_digit(ch)) begin
                            acc_next  = 63'(ch[3:0]);
                            tlen_next = L3;
                            mode_next = M_CHDIG;
                        end else begin
                            acc_next  = 63'(eres[7:0]);
                            mode_next = M_CHQ;
                        end
                    end
                    M_CHQ: begin
                        if (ch == 8'h27) begin
                            res[n] = mk(KIND_CHAR, P_STAR, tstart_reg, L4, acc_reg, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end else begin
                            res[n] = mk(KIND_END, P_STAR, pos_reg, L0, '0, NOLIT,
                                        ERR_CHARQUOTE);
                            n = n + 2'd1;
                            errl_next = 1'b1;
                            mode_next = M_IDLE;
                        end
                    end
                    M_CHDIG: begin
                        if (is_digit(ch)) begin
                            acc_next  = dec_push(acc_reg, ch[3:0]);
                            tlen_next = tinc;
                        end else if (ch == 8'h27) begin
                            res[n] = mk(KIND_CHAR, P_STAR, tstart_reg, tinc, acc_reg, NOLIT,
                                        ERR_NONE);
                            n = n + 2'd1;
                            mode_next = M_IDLE;
                        end else begin
                            res[n] = mk(KIND_END, P_STAR, pos_reg, L0, '0, NOLIT,
                                        ERR_CHARQUOTE);
                            n = n + 2'd1;
                            errl_next = 1'b1;
                            mode_next = M_IDLE;
                        end
                    end
                    default: redo = 1'b1;
                endcase
                // start a new token from the idle state
                if (redo) begin
                    mode_next = M_IDLE;
                    if (!(ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d))) begin
                        tstart_next = pos_reg;
                        unique case (ch)
                            8'h2f: mode_next = M_SLASH;
                            8'h2a, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3b, 8'h2c, 8'h5b, 8'h5d,
                            8'h23: begin
                                unique case (ch)
                                    8'h2a:   pcode[4:0] = P_STAR;
                                    8'h28:   pcode[4:0] = P_LPAREN;
                                    8'h29:   pcode[4:0] = P_RPAREN;
                                    8'h7b:   pcode[4:0] = P_LBRACE;
                                    8'h7d:   pcode[4:0] = P_RBRACE;
                                    8'h3b:   pcode[4:0] = P_SEMI;
                                    8'h2c:   pcode[4:0] = P_COMMA;
                                    8'h5b:   pcode[4:0] = P_LBRACK;
                                    8'h5d:   pcode[4:0] = P_RBRACK;
                                    default: pcode[4:0] = P_HASH;
                                endcase
                                res[n] = mk(KIND_PUNCT, pcode[4:0], pos_reg, L1, '0, NOLIT,
                                            ERR_NONE);
                                n = n + 2'd1;
                            end
                            8'h26, 8'h7c, 8'h2b, 8'h2d, 8'h3c, 8'h3e, 8'h3d, 8'h21: begin
                                esc_next  = ch;
                                mode_next = M_OP1;
                            end
                            8'h2e: mode_next = M_DOT;
                            8'h22: begin
                                mode_next = M_STR;
                                tlen_next = L1;
                            end
                            8'h27: mode_next = M_CHOPEN;
                            default: begin
                                if (is_digit(ch)) begin
                                    mode_next = M_NUM;
                                    acc_next  = 63'(ch[3:0]);
                                    tlen_next = L1;
                                end else if (is_word_head(ch)) begin
                                    mode_next = M_IDENT;
                                    wp_next   = 48'(ch);
                                    tlen_next = L1;
                                end else begin
                                    res[n] = mk(KIND_END, P_STAR, pos_reg, L0, '0, NOLIT,
                                                ERR_BADBYTE);
                                    n = n + 2'd1;
                                    errl_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            pos_next = inc_off(pos_reg);
        end
        res_count = n;
    end

    // Hold lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            pos_reg    <= '0;
            acc_reg    <= '0;
            wp_reg     <= '0;
            nlit_reg   <= '0;
            esc_reg    <= '0;
            errl_reg   <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            wp_reg     <= wp_next;
            nlit_reg   <= nlit_next;
            esc_reg    <= esc_next;
            errl_reg   <= errl_next;
        end
    end

endmodule

/* test/csl_token_checker.sv */
// Token checker for the C-subset lexer: predicts token words and compares them.
`timescale 1ns / 100ps

module csl_token_checker
    import csl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [4:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatches,
    output int           tokens_pending
);

    typedef struct packed {
        logic [4:0]  kind;
        logic [4:0]  pc;
        logic [19:0] start;
        logic [19:0] len;
        logic [62:0] val;
        logic [15:0] lit;
        logic [2:0]  err;
        logic        last;
    } token_t;

    localparam logic [19:0] POS_MAX = '1;
    localparam logic [15:0] LIT_MAX = '1;

    string kw_words [13] = '{"return", "if", "else", "while", "for", "enum", "int",
                             "long", "void", "struct", "union", "sizeof", "char"};

    token_t expected_toks[$];
    token_t byte_toks[$];

    // Lexer state mirror
    scan_mode_t  mode      = M_IDLE;
    logic [19:0] tok_start = '0;
    logic [19:0] tok_len   = '0;
    logic [19:0] pos       = '0;
    logic [62:0] acc       = '0;
    logic [47:0] wp        = '0;
    logic [15:0] lit_next  = '0;
    logic [7:0]  op_byte   = '0;
    logic        latched   = 1'b0;

    assign tokens_pending = expected_toks.size();

    function automatic logic [19:0] pos_inc(input logic [19:0] x);
        return (x == POS_MAX) ? x : x + 20'd1;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic name_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Append a decimal digit, saturating at the value maximum
    function automatic logic [62:0] push_digit(input logic [62:0] a, input logic [7:0] c);
        logic [62:0] d;
        d = 63'(c - 8'h30);
        if (a > (VAL_MAX - d) / 10) return VAL_MAX;
        return a * 10 + d;
    endfunction

    function automatic int op_single(input logic [7:0] f);
        case (f)
            "&": return P_AND;
            "+": return P_PLUS;
            "-": return P_MINUS;
            "<": return P_LT;
            ">": return P_GT;
            "=": return P_ASSIGN;
            "!": return P_NOT;
            default: return -1;
        endcase
    endfunction

    function automatic int op_pair(input logic [7:0] f, input logic [7:0] c);
        if (f == "&" && c == "&") return P_ANDAND;
        if (f == "|" && c == "|") return P_OROR;
        if (f == "+" && c == "+") return P_INC;
        if (f == "-" && c == "-") return P_DEC;
        if (f == "-" && c == ">") return P_ARROW;
        if (c == "=") begin
            if (f == "<") return P_LE;
            if (f == ">") return P_GE;
            if (f == "=") return P_EQEQ;
            if (f == "!") return P_NE;
        end
        return -1;
    endfunction

    task automatic add_tok(input logic [4:0] kind, input logic [4:0] pc,
                           input logic [19:0] start, input logic [19:0] len,
                           input logic [62:0] val, input logic [15:0] lit,
                           input logic [2:0] err);
        token_t t;
        t = '{kind, pc, start, len, val, lit, err, 1'b0};
        byte_toks.push_back(t);
    endtask

    task automatic punct_tok(input int pc, input logic [19:0] start, input logic [19:0] len);
        add_tok(KIND_PUNCT, 5'(pc), start, len, '0, '0, ERR_NONE);
    endtask

    task automatic raise_fault(input logic [2:0] code, input logic [19:0] at);
        add_tok(KIND_END, P_STAR, at, '0, '0, '0, code);
        latched = 1'b1;
        mode = M_IDLE;
    endtask

    // Classify the word as keyword or identifier
    task automatic word_tok();
        logic [4:0]  kind;
        logic [47:0] packed_w;
        kind = KIND_IDENT;
        for (int k = 0; k < 13; k++) begin
            packed_w = '0;
            for (int i = 0; i < kw_words[k].len(); i++)
                packed_w = {packed_w[39:0], kw_words[k][i]};
            if (kind == KIND_IDENT && tok_len == 20'(kw_words[k].len()) && wp == packed_w)
                kind = KIND_KW0 + 5'(k);
        end
        add_tok(kind, P_STAR, tok_start, tok_len, '0, '0, ERR_NONE);
    endtask

    // Start a token from the between-tokens state
    task automatic idle_scan(input logic [7:0] c);
        if (c == " " || (c >= 8'h09 && c <= 8'h0d)) return;
        tok_start = pos;
        case (c)
            "/": mode = M_SLASH;
            "*": punct_tok(P_STAR, pos, 1);
            "(": punct_tok(P_LPAREN, pos, 1);
            ")": punct_tok(P_RPAREN, pos, 1);
            "{": punct_tok(P_LBRACE, pos, 1);
            "}": punct_tok(P_RBRACE, pos, 1);
            ";": punct_tok(P_SEMI, pos, 1);
            ",": punct_tok(P_COMMA, pos, 1);
            "[": punct_tok(P_LBRACK, pos, 1);
            "]": punct_tok(P_RBRACK, pos, 1);
            "#": punct_tok(P_HASH, pos, 1);
            "&", "|", "+", "-", "<", ">", "=", "!": begin
                op_byte = c;
                mode = M_OP1;
            end
            ".": mode = M_DOT;
            8'h22: begin
                mode = M_STR;
                tok_len = 1;
            end
            8'h27: mode = M_CHOPEN;
            default: begin
                if (digit_byte(c)) begin
                    mode = M_NUM;
                    acc = 63'(c - 8'h30);
                    tok_len = 1;
                end else if (name_head(c)) begin
                    mode = M_IDENT;
                    wp = 48'(c);
                    tok_len = 1;
                end else begin
                    raise_fault(ERR_BADBYTE, pos);
                end
            end
        endcase
    endtask

    // Advance the scanner by one byte
    task automatic scan_step(input logic [7:0] c);
        int    pc;
        logic  hit;
        logic [7:0] ev;
        case (mode)
            M_SLASH: begin
                if (c == "/") begin mode = M_LINEC; return; end
                if (c == "*") begin mode = M_BLOCKC; return; end
                punct_tok(P_SLASH, tok_start, 1);
            end
            M_OP1: begin
                pc = op_pair(op_byte, c);
                if (pc >= 0) begin
                    punct_tok(pc, tok_start, 2);
                    mode = M_IDLE;
                    return;
                end
                pc = op_single(op_byte);
                if (pc < 0) begin
                    raise_fault(ERR_BADBYTE, tok_start);
                    return;
                end
                punct_tok(pc, tok_start, 1);
            end
            M_DOT: begin
                if (c == ".") begin mode = M_DOT2; return; end
                punct_tok(P_DOT, tok_start, 1);
            end
            M_DOT2: begin
                if (c == ".") begin
                    punct_tok(P_ELLIPS, tok_start, 3);
                    mode = M_IDLE;
                    return;
                end
                punct_tok(P_DOT, tok_start, 1);
                punct_tok(P_DOT, pos_inc(tok_start), 1);
            end
            M_IDENT: begin
                if (name_head(c) || digit_byte(c)) begin
                    wp = {wp[39:0], c};
                    tok_len = pos_inc(tok_len);
                    return;
                end
                word_tok();
            end
            M_NUM: begin
                if (digit_byte(c)) begin
                    acc = push_digit(acc, c);
                    tok_len = pos_inc(tok_len);
                    return;
                end
                add_tok(KIND_NUMBER, P_STAR, tok_start, tok_len, acc, '0, ERR_NONE);
            end
            M_LINEC: begin
                if (c == 8'h0a) mode = M_IDLE;
                return;
            end
            M_BLOCKC: begin
                if (c == "*") mode = M_BLOCKSTAR;
                return;
            end
            M_BLOCKSTAR: begin
                if (c == "/") mode = M_IDLE;
                else if (c != "*") mode = M_BLOCKC;
                return;
            end
            M_STR: begin
                tok_len = pos_inc(tok_len);
                if (c == 8'h5c) begin
                    mode = M_STRESC;
                end else if (c == 8'h22) begin
                    add_tok(KIND_STRING, P_STAR, tok_start, tok_len, '0, lit_next, ERR_NONE);
                    if (lit_next != LIT_MAX) lit_next++;
                    mode = M_IDLE;
                end
                return;
            end
            M_STRESC: begin
                tok_len = pos_inc(tok_len);
                mode = M_STR;
                return;
            end
            M_CHOPEN: begin
                if (c == 8'h5c) begin
                    mode = M_CHBS;
                end else begin
                    acc = 63'(c);
                    mode = M_CHPLAIN;
                end
                return;
            end
            M_CHPLAIN: begin
                add_tok(KIND_CHAR, P_STAR, tok_start, 3, acc, '0, ERR_NONE);
                mode = M_IDLE;
                return;
            end
            M_CHBS: begin
                hit = 1'b1;
                case (c)
                    "a": ev = 8'h07;
                    "b": ev = 8'h08;
                    "e": ev = 8'h1b;
                    "f": ev = 8'h0c;
                    "n": ev = 8'h0a;
                    "r": ev = 8'h0d;
                    "t": ev = 8'h09;
                    "v": ev = 8'h0b;
                    8'h5c, 8'h27, 8'h22, "?": ev = c;
                    default: begin
                        hit = 1'b0;
                        ev = c;
                    end
                endcase
                if (!hit && digit_byte(c)) begin
                    acc = 63'(c - 8'h30);
                    tok_len = 3;
                    mode = M_CHDIG;
                end else begin
                    acc = 63'(ev);
                    mode = M_CHQ;
                end
                return;
            end
            M_CHQ: begin
                if (c == 8'h27) begin
                    add_tok(KIND_CHAR, P_STAR, tok_start, 4, acc, '0, ERR_NONE);
                    mode = M_IDLE;
                end else begin
                    raise_fault(ERR_CHARQUOTE, pos);
                end
                return;
            end
            M_CHDIG: begin
                if (digit_byte(c)) begin
                    acc = push_digit(acc, c);
                    tok_len = pos_inc(tok_len);
                end else if (c == 8'h27) begin
                    add_tok(KIND_CHAR, P_STAR, tok_start, pos_inc(tok_len), acc, '0, ERR_NONE);
                    mode = M_IDLE;
                end else begin
                    raise_fault(ERR_CHARQUOTE, pos);
                end
                return;
            end
            default: ;
        endcase
        mode = M_IDLE;
        idle_scan(c);
    endtask

    // Close whatever token is open at end of text
    task automatic flush_open();
        int pc;
        case (mode)
            M_SLASH: punct_tok(P_SLASH, tok_start, 1);
            M_OP1: begin
                pc = op_single(op_byte);
                if (pc < 0) raise_fault(ERR_BADBYTE, tok_start);
                else punct_tok(pc, tok_start, 1);
            end
            M_DOT: punct_tok(P_DOT, tok_start, 1);
            M_DOT2: begin
                punct_tok(P_DOT, tok_start, 1);
                punct_tok(P_DOT, pos_inc(tok_start), 1);
            end
            M_IDENT: word_tok();
            M_NUM: add_tok(KIND_NUMBER, P_STAR, tok_start, tok_len, acc, '0, ERR_NONE);
            M_BLOCKC, M_BLOCKSTAR: raise_fault(ERR_COMMENT, tok_start);
            M_STR, M_STRESC: raise_fault(ERR_STRING, pos);
            M_CHOPEN, M_CHPLAIN, M_CHBS, M_CHQ, M_CHDIG: raise_fault(ERR_CHARQUOTE, pos);
            default: ;
        endcase
    endtask

    task automatic restart_text();
        mode = M_IDLE;
        tok_start = '0;
        tok_len = '0;
        pos = '0;
        acc = '0;
        wp = '0;
        op_byte = '0;
        latched = 1'b0;
    endtask

    // Work out the tokens one accepted word yields
    task automatic predict_tokens(input logic [7:0] c, input logic eoi);
        byte_toks.delete();
        if (eoi) begin
            if (!latched) flush_open();
            add_tok(KIND_END, P_STAR, pos, 1, '0, '0, ERR_NONE);
            restart_text();
        end else begin
            if (!latched) scan_step(c);
            pos = pos_inc(pos);
        end
        if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].last = 1'b1;
        foreach (byte_toks[i]) expected_toks.push_back(byte_toks[i]);
    endtask

    // Compare outgoing words, then fold in the incoming byte
    always @(posedge aclk) begin
        token_t want;
        token_t got;
        if (!aresetn) begin
            restart_text();
            lit_next = '0;
            expected_toks.delete();
            mismatches <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[4:0], m_tdata[24:5], m_tdata[44:25],
                        m_tdata[107:45], m_tdata[123:108], m_tdata[126:124], m_tlast};
                if (expected_toks.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected token word kind=%0d start=%0d",
                                 $realtime, got.kind, got.start);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_toks.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: token mismatch", $realtime);
                            $display("  exp kind=%0d pc=%0d start=%0d len=%0d val=%0d lit=%0d err=%0d last=%0d",
                                     want.kind, want.pc, want.start, want.len, want.val,
                                     want.lit, want.err, want.last);
                            $display("  got kind=%0d pc=%0d start=%0d len=%0d val=%0d lit=%0d err=%0d last=%0d",
                                     got.kind, got.pc, got.start, got.len, got.val,
                                     got.lit, got.err, got.last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
        end
    end

endmodule

/* test/tb_c_subset_lexer.sv */
// Top of the C-subset lexer testbench: source text stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module tb_c_subset_lexer;

    localparam int SRC_BYTES = 480;
    localparam int IDLE_LIMIT = 3000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;
    int           mismatches;
    int           tokens_pending;

    logic [8:0]   src_words[$];   // {end_of_input, ch}
    logic         calm;
    logic         hold_off_req;
    int           idle_cycles;

    string kw_words [13] = '{"return", "if", "else", "while", "for", "enum", "int",
                             "long", "void", "struct", "union", "sizeof", "char"};
    string punct_words [31] = '{"*", "/", "(", ")", "{", "}", ";", ",", "[", "]", "#",
                                "&&", "&", "||", "++", "+", "...", ".", "--", "->", "-",
                                "<=", "<", ">=", ">", "==", "=", "!=", "!", "|", ".."};
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string esc_chars = "abefnrtv\\'\"?";

    c_subset_lexer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csl_token_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic put_byte(input logic [7:0] c);
        src_words.push_back({1'b0, c});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_end();
        src_words.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            put_byte(($urandom_range(0, 3) == 0) ? "9" : 8'(8'h30 + $urandom_range(0, 9)));
    endtask

    // Append one random fragment of C-like text
    task automatic put_fragment();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            put_text(kw_words[$urandom_range(0, 12)]);
        end else if (sel < 24) begin
            put_byte(word_chars[$urandom_range(0, 52)]);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) put_byte(word_chars[$urandom_range(0, 62)]);
        end else if (sel < 34) begin
            put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(18, 22)
                                                   : $urandom_range(1, 5));
        end else if (sel < 56) begin
            put_text(punct_words[$urandom_range(0, ($urandom_range(0, 9) == 0) ? 30 : 28)]);
        end else if (sel < 64) begin
            put_byte(8'h22);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    put_byte(8'h5c);
                    put_byte(8'($urandom_range(0, 255)));
                end else begin
                    put_byte(8'($urandom_range(8'h23, 255)));
                end
            end
            put_byte(8'h22);
        end else if (sel < 74) begin
            put_byte(8'h27);
            case ($urandom_range(0, 4))
                0: begin
                    put_byte(8'($urandom_range(0, 255)));
                    put_byte(8'h27);
                end
                1: begin
                    put_byte(8'h5c);
                    put_byte(esc_chars[$urandom_range(0, 11)]);
                    put_byte(8'h27);
                end
                2: begin
                    put_byte(8'h5c);
                    put_digits(($urandom_range(0, 3) == 0) ? 21 : $urandom_range(1, 3));
                    put_byte(8'h27);
                end
                3: begin
                    put_byte(8'h5c);
                    put_byte(8'($urandom_range(0, 255)));
                    put_byte(8'h27);
                end
                default: begin
                    put_byte(8'h5c);
                    put_byte(esc_chars[$urandom_range(0, 11)]);
                    put_byte(8'($urandom_range(8'h28, 8'h7e)));
                end
            endcase
        end else if (sel < 80) begin
            put_text($urandom_range(0, 1) ? "//" : "/*");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                put_byte(($urandom_range(0, 3) == 0) ? "*" : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) != 0) put_text("*/\n");
        end else if (sel < 90) begin
            put_byte(8'($urandom_range(8'h09, 8'h0d)));
        end else if (sel < 94) begin
            put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_end();
        end
        if ($urandom_range(0, 2) != 0) put_byte(" ");
    endtask

    // Build the source text: short directed texts, then random fragments
    task automatic build_source();
        put_byte(8'h00);
        put_byte(8'hff);
        put_end();
        put_text("x|y");
        put_end();
        put_text("..");
        put_end();
        put_text("/*a");
        put_end();
        put_text("\"a");
        put_end();
        put_text("'\\7");
        put_end();
        while (src_words.size() < SRC_BYTES) put_fragment();
        put_end();
    endtask

    // Sink: random stalls, one long hold-off on request, always ready at the end
    initial begin
        m_tready <= 1'b0;
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
                if ($urandom_range(0, 1) == 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge aclk);
                end
            end
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("c_subset_lexer regression: fail");
            $finish;
        end
    end

    // Source: feed bytes with random gaps, then wait for the last tokens
    initial begin
        int total;
        calm = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        build_source();
        total = src_words.size();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < total; i++) begin
            if (i == total / 3) hold_off_req = 1'b1;
            if (i == (total * 17) / 20) calm = 1'b1;
            s_tvalid <= 1'b1;
            s_tdata <= src_words[i][7:0];
            s_tlast <= src_words[i][8];
            do @(posedge aclk); while (!s_tready);
            if (!calm && !hold_off_req && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (tokens_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && tokens_pending == 0)
            $display("c_subset_lexer regression: pass");
        else
            $display("c_subset_lexer regression: fail");
        $finish;
    end

endmodule
